@@ design/tsa_pkg.sv @@
// shared types, constants and the arctangent table for the trajectory step accumulator
package tsa_pkg;

   // cordic gain 0.60725... in Q30
   localparam logic [29:0] GAIN_Q30 = 30'd652032874;

   // width of the rotating vector: |y| < 2^46, one guard bit and a sign bit
   localparam int XY_W = 48;
   // width of the residual angle in 2^-32 turn units, with headroom
   localparam int Z_W = 34;

   localparam int ATAN_COUNT = 24;
   localparam int ATAN_IDX_W = 5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ROTATE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic load;     // take a new word, advance the heading
      logic setup;    // build the start vector and angle
      logic rotate;   // one cordic iteration
      logic update;   // move the position, fill the output register
   } dp_cmd_type;

   typedef struct packed {
      logic rotate_last;
   } dp_status_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:    val = 32'h20000000;
         5'd1:    val = 32'h12E4051E;
         5'd2:    val = 32'h09FB385B;
         5'd3:    val = 32'h051111D4;
         5'd4:    val = 32'h028B0D43;
         5'd5:    val = 32'h0145D7E1;
         5'd6:    val = 32'h00A2F61E;
         5'd7:    val = 32'h00517C55;
         5'd8:    val = 32'h0028BE53;
         5'd9:    val = 32'h00145F2F;
         5'd10:   val = 32'h000A2F98;
         5'd11:   val = 32'h000517CC;
         5'd12:   val = 32'h00028BE6;
         5'd13:   val = 32'h000145F3;
         5'd14:   val = 32'h0000A2FA;
         5'd15:   val = 32'h0000517D;
         5'd16:   val = 32'h000028BE;
         5'd17:   val = 32'h0000145F;
         5'd18:   val = 32'h00000A30;
         5'd19:   val = 32'h00000518;
         5'd20:   val = 32'h0000028C;
         5'd21:   val = 32'h00000146;
         5'd22:   val = 32'h000000A3;
         5'd23:   val = 32'h00000051;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

@@ design/tsa_ctrl.sv @@
// sequencing state machine and output valid for the trajectory step accumulator
module tsa_ctrl
   import tsa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_ROTATE;
         end
         ST_ROTATE: begin
            cmd.rotate = 1'b1;
            if (status.rotate_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // wait for the output register to free up
            if (!out_valid_ff || !rsp_stall) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.update) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

@@ design/tsa_datapath.sv @@
// heading, cordic rotator, saturating position and output registers
module tsa_datapath
   import tsa_pkg::*;
#(
   parameter int ANGLE_BITS = 16,
   parameter int POS_BITS   = 32,
   parameter int STEPS      = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic [ANGLE_BITS-1:0] req_deflection,
   input  logic [15:0]           req_step_length,
   input  logic                  req_restart,
   output logic [POS_BITS-1:0]   rsp_new_x,
   output logic [POS_BITS-1:0]   rsp_new_y,
   output logic [ANGLE_BITS-1:0] rsp_new_heading
);

   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   // rounded displacement: bits 47..30 of the vector
   localparam int D_W   = XY_W - 30;
   localparam int SUM_W = ((POS_BITS > D_W) ? POS_BITS : D_W) + 1;
   localparam logic signed [SUM_W-1:0] POS_MAX =
      {{(SUM_W-POS_BITS+1){1'b0}}, {(POS_BITS-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] POS_MIN = ~POS_MAX;
   localparam logic signed [XY_W-1:0] ROUND_HALF = XY_W'(64'd1 << 29);

   // architectural state
   logic        [ANGLE_BITS-1:0] heading_ff, heading_in;
   logic signed [POS_BITS-1:0]   pos_x_ff, pos_x_in;
   logic signed [POS_BITS-1:0]   pos_y_ff, pos_y_in;

   // per-word working registers
   logic        [15:0]           len_ff;
   logic                         restart_ff;
   logic signed [XY_W-1:0]       x_ff, x_in;
   logic signed [XY_W-1:0]       y_ff, y_in;
   logic signed [Z_W-1:0]        z_ff, z_in;
   logic        [CNT_W-1:0]      cnt_ff, cnt_in;

   logic [POS_BITS-1:0]   out_x_ff, out_y_ff;
   logic [ANGLE_BITS-1:0] out_heading_ff;

   // start vector
   logic        [45:0]     prod;
   logic signed [XY_W-1:0] prod_ext;
   logic        [31:0]     z_turn;
   logic                   half_turn;

   // rotation
   logic signed [XY_W-1:0] x_shift, y_shift;
   logic signed [Z_W-1:0]  atan_ext;

   // position update
   logic signed [XY_W-1:0]   x_round, y_round;
   logic signed [D_W-1:0]    dx, dy;
   logic signed [SUM_W-1:0]  base_x, base_y, sum_x, sum_y;
   logic signed [POS_BITS-1:0] sat_x, sat_y;

   function automatic logic [45:0] req_len_mult(input logic [15:0] len);
      return 46'(len) * 46'(GAIN_Q30);
   endfunction

   assign heading_in = (req_restart ? '0 : heading_ff) + req_deflection;

   assign prod     = req_len_mult(len_ff);
   assign prod_ext = XY_W'(prod);
   assign z_turn   = {heading_ff, {(32-ANGLE_BITS){1'b0}}};
   // second and third quadrant: flip the start vector, pull the angle back half a turn
   assign half_turn = z_turn[31] ^ z_turn[30];

   assign x_shift  = x_ff >>> cnt_ff;
   assign y_shift  = y_ff >>> cnt_ff;
   assign atan_ext = Z_W'(atan_turn(ATAN_IDX_W'(cnt_ff)));

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      cnt_in = cnt_ff;
      if (cmd.setup) begin
         x_in   = '0;
         y_in   = half_turn ? prod_ext : -prod_ext;
         z_in   = Z_W'($signed({z_turn[31] ^ half_turn, z_turn[30:0]}));
         cnt_in = '0;
      end else if (cmd.rotate) begin
         if (!z_ff[Z_W-1]) begin
            x_in = x_ff - y_shift;
            y_in = y_ff + x_shift;
            z_in = z_ff - atan_ext;
         end else begin
            x_in = x_ff + y_shift;
            y_in = y_ff - x_shift;
            z_in = z_ff + atan_ext;
         end
         cnt_in = cnt_ff + 1'b1;
      end
   end

   assign status.rotate_last = (cnt_ff == CNT_W'(STEPS-1));

   // round half up to whole position units
   assign x_round = x_ff + ROUND_HALF;
   assign y_round = y_ff + ROUND_HALF;
   assign dx      = x_round[XY_W-1:30];
   assign dy      = y_round[XY_W-1:30];

   assign base_x = restart_ff ? '0 : SUM_W'(pos_x_ff);
   assign base_y = restart_ff ? '0 : SUM_W'(pos_y_ff);
   assign sum_x  = base_x + SUM_W'(dx);
   assign sum_y  = base_y + SUM_W'(dy);

   always_comb begin
      if (sum_x > POS_MAX) begin
         sat_x = POS_MAX[POS_BITS-1:0];
      end else if (sum_x < POS_MIN) begin
         sat_x = POS_MIN[POS_BITS-1:0];
      end else begin
         sat_x = sum_x[POS_BITS-1:0];
      end
      if (sum_y > POS_MAX) begin
         sat_y = POS_MAX[POS_BITS-1:0];
      end else if (sum_y < POS_MIN) begin
         sat_y = POS_MIN[POS_BITS-1:0];
      end else begin
         sat_y = sum_y[POS_BITS-1:0];
      end
   end

   assign pos_x_in = cmd.update ? sat_x : pos_x_ff;
   assign pos_y_in = cmd.update ? sat_y : pos_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff <= '0;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
      end else begin
         if (cmd.load) begin
            heading_ff <= heading_in;
         end
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         len_ff     <= req_step_length;
         restart_ff <= req_restart;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      cnt_ff <= cnt_in;
      if (cmd.update) begin
         out_x_ff       <= sat_x;
         out_y_ff       <= sat_y;
         out_heading_ff <= heading_ff;
      end
   end

   assign rsp_new_x       = out_x_ff;
   assign rsp_new_y       = out_y_ff;
   assign rsp_new_heading = out_heading_ff;

endmodule

@@ design/trajectory_step_accumulator_top.sv @@
// top level of the trajectory step accumulator: controller plus datapath
// one word at a time: the single shared cordic rotator runs one iteration per cycle,
//   and the next word is taken only in idle
// reset: synchronous, active high; clears position, heading and all valid flags
// the output register holds a finished result while the next word is being worked on
module trajectory_step_accumulator_top
   import tsa_pkg::*;
#(
   parameter int ANGLE_BITS   = 16,
   parameter int POS_BITS     = 32,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel: one step per word
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ANGLE_BITS-1:0] req_deflection,
   input  logic [15:0]           req_step_length,
   input  logic                  req_restart,
   // response channel: new point and heading
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [POS_BITS-1:0]   rsp_new_x,
   output logic [POS_BITS-1:0]   rsp_new_y,
   output logic [ANGLE_BITS-1:0] rsp_new_heading
);

   // the arctangent table has 24 entries, so CORDIC_STEPS above 24 is capped to 24
   localparam int STEPS = (CORDIC_STEPS > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STEPS;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: idle -> setup -> rotate (STEPS iterations) -> update
   tsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // heading accumulate, cordic rotation of (0, -len*gain), saturating move
   tsa_datapath #(
      .ANGLE_BITS (ANGLE_BITS),
      .POS_BITS   (POS_BITS),
      .STEPS      (STEPS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_deflection  (req_deflection),
      .req_step_length (req_step_length),
      .req_restart     (req_restart),
      .rsp_new_x       (rsp_new_x),
      .rsp_new_y       (rsp_new_y),
      .rsp_new_heading (rsp_new_heading)
   );

endmodule
